FILE: sv/fsc_pkg.sv
// fsc_pkg: shared widths, register map and defaults for the fish-eye
// source coordinate block. No dependencies.
`default_nettype none
package fsc_pkg;
    localparam int COORD_W = 12;
    localparam int DIM_W = 13;
    localparam int K_W = 16;
    localparam int SCALE_W = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int MAX_DIM_DEF = 4096;
    localparam int NORM_FRAC_DEF = 16;

    localparam logic [DIM_W-1:0] WIDTH_RST = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [K_W-1:0] K_RST = 16'd0;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_DISTORTION = 2'd2,
        REG_ZOOM_SCALE = 2'd3
    } cfg_addr_t;
endpackage
`default_nettype wire

FILE: sv/fisheye_source_coordinate.sv
// fisheye_source_coordinate: maps a destination pixel to its fish-eye source
// pixel and an in-frame flag. Uses fsc_pkg and fsc_div.
//
// Takes one destination word per clock and gives one source word per clock
// while no stall is held. The path runs through three bit-serial pipelined
// dividers in series: normalization by the frame size, division by the
// distortion factor and division by the zoom scale. A stall on the source
// side while source_valid is high freezes the whole pipeline and is seen
// at once as dest_stall. Configuration registers may only change while no
// words are in flight. There is no start-up sweep after reset.
`default_nettype none
module fisheye_source_coordinate
    import fsc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int NORM_FRAC = NORM_FRAC_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                dest_valid,
    output logic                dest_stall,
    input  logic [COORD_W-1:0]  dest_x,
    input  logic [COORD_W-1:0]  dest_y,
    output logic                source_valid,
    input  logic                source_stall,
    output logic [COORD_W-1:0]  source_col,
    output logic [COORD_W-1:0]  source_row,
    output logic                in_bounds
);
    localparam int F = NORM_FRAC;
    localparam int NW1 = F + 13;
    localparam int NW2 = 2 * F + 2;
    localparam int DW2 = F + 7;
    localparam int NW3 = F + 19;

    localparam logic [DIM_W-1:0] MAXD = (MAX_DIM > 8191) ? 13'd8191 : DIM_W'(MAX_DIM);
    localparam logic [NW1-1:0] LIM1 = NW1'(1) << (F + 1);
    localparam logic signed [F+7:0] ONE_D = (F + 8)'(1) << F;
    localparam logic [2*F+2:0] LIM2 = (2 * F + 3)'(1) << (F + 10);
    localparam logic [NW3-1:0] LIM3 = NW3'(1) << (F + 2);
    localparam logic signed [F+4:0] ONE_U = (F + 5)'(1) << F;
    localparam logic signed [F+18:0] PBIAS = ((F + 19)'(1) << (F + 1)) - (F + 19)'(1);

    // configuration
    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;
    logic [K_W-1:0]     distortion_reg;
    logic [SCALE_W-1:0] zoom_scale_reg;
    logic               wr_en;
    cfg_addr_t          cfg_addr;

    assign pready = 1'b1;
    assign cfg_addr = cfg_addr_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            distortion_reg <= K_RST;
            zoom_scale_reg <= SCALE_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  image_width_reg <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                REG_DISTORTION:   distortion_reg <= pwdata[K_W-1:0];
                REG_ZOOM_SCALE:   zoom_scale_reg <= pwdata[SCALE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_addr)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height_reg);
            REG_DISTORTION:   prdata = DATA_W'(distortion_reg);
            REG_ZOOM_SCALE:   prdata = DATA_W'(zoom_scale_reg);
        endcase
    end

    logic [DIM_W-1:0]   dim [2];
    logic [SCALE_W-1:0] scale_eff;
    logic               dim_zero;

    assign dim[0] = (image_width_reg > MAXD) ? MAXD : image_width_reg;
    assign dim[1] = (image_height_reg > MAXD) ? MAXD : image_height_reg;
    assign scale_eff = (zoom_scale_reg == '0) ? SCALE_W'(1) : zoom_scale_reg;
    assign dim_zero = (dim[0] == '0) || (dim[1] == '0);

    // pipeline control
    logic       en;
    logic       src_valid_reg;
    logic [4:0] va_reg;
    logic [1:0] vb_reg;

    assign dest_stall = src_valid_reg && source_stall;
    assign en = !dest_stall;
    assign source_valid = src_valid_reg;

    // per-lane signals, lane 0 is x, lane 1 is y
    logic [COORD_W-1:0]     coord [2];
    logic signed [DIM_W+1:0] a_diff [2];
    logic [DIM_W-1:0]       a_mag [2];
    logic [NW1-1:0]         num1 [2];
    logic                   v1 [2];
    logic [NW1-1:0]         q1 [2];
    logic [0:0]             s1 [2];
    logic [F+1:0]           nmag1 [2];

    logic signed [F+2:0]    n1_reg [2];
    logic signed [F+2:0]    n2_reg [2];
    logic signed [F+2:0]    n3_reg [2];
    logic signed [F+2:0]    n4_reg [2];
    logic signed [F+2:0]    n5_reg [2];
    logic signed [2*F+5:0]  sq [2];
    logic [2*F+2:0]         sq_reg [2];

    logic [2*F+3:0]         r2_sum;
    logic [F+3:0]           r2_reg;
    logic signed [F+20:0]   kr_reg;
    logic signed [F+20:0]   kr_adj;
    logic signed [F+7:0]    d_reg;
    logic                   d_zero;
    logic [F+6:0]           d_mag;

    logic [F+1:0]           nmag5 [2];
    logic [NW2-1:0]         num2 [2];
    logic [DW2-1:0]         den2;
    logic [0:0]             sgn2 [2];
    logic                   v2 [2];
    logic [NW2-1:0]         q2 [2];
    logic [0:0]             s2 [2];

    logic [2*F+2:0]         q2_ext [2];
    logic [NW3-1:0]         num3 [2];
    logic                   v3 [2];
    logic [NW3-1:0]         q3 [2];
    logic [0:0]             s3 [2];

    logic [F+2:0]           smag [2];
    logic signed [F+3:0]    s_val [2];
    logic signed [F+4:0]    u_next [2];
    logic signed [F+4:0]    u_reg [2];
    logic signed [F+18:0]   prod_reg [2];
    logic signed [F+18:0]   prod_adj [2];
    logic [17:0]            pix [2];
    logic                   pix_ok [2];

    assign coord[0] = dest_x;
    assign coord[1] = dest_y;

    assign d_zero = (d_reg == '0);
    assign d_mag = d_reg[F+7] ? DW2'(-d_reg) : DW2'(d_reg);
    assign den2 = d_zero ? DW2'(1) : d_mag;

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        assign a_diff[l] = $signed({2'b00, coord[l], 1'b0}) - $signed({2'b00, dim[l]});
        assign a_mag[l] = a_diff[l][DIM_W+1] ? DIM_W'(-a_diff[l]) : DIM_W'(a_diff[l]);
        assign num1[l] = {a_mag[l], {F{1'b0}}};

        fsc_div #(.NW(NW1), .DW(DIM_W), .PW(1)) u_div_norm (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (dest_valid),
            .num      (num1[l]),
            .den      (dim[l]),
            .side_in  (a_diff[l][DIM_W+1]),
            .out_valid(v1[l]),
            .quo      (q1[l]),
            .side_out (s1[l])
        );

        assign nmag1[l] = (q1[l] > LIM1) ? LIM1[F+1:0] : q1[l][F+1:0];
        assign sq[l] = n1_reg[l] * n1_reg[l];

        assign nmag5[l] = n5_reg[l][F+2] ? (F + 2)'(-n5_reg[l]) : (F + 2)'(n5_reg[l]);
        assign num2[l] = d_zero ? NW2'(nmag5[l]) : {nmag5[l], {F{1'b0}}};
        assign sgn2[l] = n5_reg[l][F+2] ^ (d_reg[F+7] && !d_zero);

        fsc_div #(.NW(NW2), .DW(DW2), .PW(1)) u_div_warp (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (va_reg[4]),
            .num      (num2[l]),
            .den      (den2),
            .side_in  (sgn2[l]),
            .out_valid(v2[l]),
            .quo      (q2[l]),
            .side_out (s2[l])
        );

        // quotients beyond this bound saturate for any scale
        assign q2_ext[l] = {1'b0, q2[l]};
        assign num3[l] = (q2_ext[l] > LIM2) ? {LIM2[F+10:0], 8'd0}
                                             : {q2_ext[l][F+10:0], 8'd0};

        fsc_div #(.NW(NW3), .DW(SCALE_W), .PW(1)) u_div_zoom (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v2[0]),
            .num      (num3[l]),
            .den      (scale_eff),
            .side_in  (s2[l]),
            .out_valid(v3[l]),
            .quo      (q3[l]),
            .side_out (s3[l])
        );

        assign smag[l] = (q3[l] > LIM3) ? LIM3[F+2:0] : q3[l][F+2:0];
        assign s_val[l] = s3[l][0] ? -$signed({1'b0, smag[l]}) : $signed({1'b0, smag[l]});
        assign u_next[l] = $signed({s_val[l][F+3], s_val[l]}) + ONE_U;

        assign prod_adj[l] = prod_reg[l] + (prod_reg[l][F+18] ? PBIAS : '0);
        assign pix[l] = prod_adj[l][F+18:F+1];
        assign pix_ok[l] = !pix[l][17] && (pix[l][16:0] < {4'b0000, dim[l]});
    end

    assign r2_sum = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
    assign kr_adj = kr_reg + (kr_reg[F+20] ? (F + 21)'(4095) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= '0;
            vb_reg <= '0;
            src_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= {va_reg[3:0], v1[0]};
            vb_reg <= {vb_reg[0], v3[0]};
            src_valid_reg <= vb_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                n1_reg[l] <= s1[l][0] ? -$signed({1'b0, nmag1[l]}) : $signed({1'b0, nmag1[l]});
                n2_reg[l] <= n1_reg[l];
                sq_reg[l] <= sq[l][2*F+2:0];
                n3_reg[l] <= n2_reg[l];
                n4_reg[l] <= n3_reg[l];
                n5_reg[l] <= n4_reg[l];
                u_reg[l] <= u_next[l];
                prod_reg[l] <= u_reg[l] * $signed({1'b0, dim[l]});
            end
            r2_reg <= r2_sum[2*F+3:F];
            kr_reg <= $signed(distortion_reg) * $signed({1'b0, r2_reg});
            d_reg <= ONE_D - $signed(kr_adj[F+19:12]);
            if (pix_ok[0] && pix_ok[1] && !dim_zero)
            begin
                source_col <= pix[0][COORD_W-1:0];
                source_row <= pix[1][COORD_W-1:0];
                in_bounds <= 1'b1;
            end
            else
            begin
                source_col <= '0;
                source_row <= '0;
                in_bounds <= 1'b0;
            end
        end
    end

    a_lanes_norm: assert property (@(posedge clk) disable iff (!rst_n) v1[0] == v1[1])
        else $error("x and y normalize lanes out of step");
    a_lanes_warp: assert property (@(posedge clk) disable iff (!rst_n) v2[0] == v2[1])
        else $error("x and y warp lanes out of step");
    a_lanes_zoom: assert property (@(posedge clk) disable iff (!rst_n) v3[0] == v3[1])
        else $error("x and y zoom lanes out of step");
    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        source_valid && !in_bounds |-> source_col == '0 && source_row == '0)
        else $error("out-of-frame word carries nonzero coordinates");
endmodule
`default_nettype wire

FILE: sv/fsc_div.sv
// fsc_div: pipelined unsigned restoring divider, one quotient bit per stage,
// with a side-band word carried alongside. Depends on nothing.
`default_nettype none
module fsc_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [PW-1:0] side_out
);
    logic [NW:0]   valid_reg;
    logic [DW-1:0] rem_reg [0:NW];
    logic [NW-1:0] nq_reg [0:NW];
    logic [DW-1:0] den_reg [0:NW];
    logic [PW-1:0] side_reg [0:NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            nq_reg[0] <= num;
            den_reg[0] <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] nq_next;

        assign trial = {rem_reg[i], nq_reg[i][NW-1]};
        assign diff = trial - {1'b0, den_reg[i]};
        assign ge = trial >= {1'b0, den_reg[i]};
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign nq_next = {nq_reg[i][NW-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= rem_next;
                nq_reg[i+1] <= nq_next;
                den_reg[i+1] <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[NW];
    assign quo = nq_reg[NW];
    assign side_out = side_reg[NW];
endmodule
`default_nettype wire
